// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polynomial kernel block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PKE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");

// Checked on every rising edge, reset included.
`define PKE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/core/pke_pkg.sv =====
// ----------------------------------------------------------------------------
// pke_pkg
// Types, constants and codes shared by the polynomial kernel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pke_pkg;

  localparam int FEATURE_BITS = 16;
  localparam int ACC_BITS     = 48;
  localparam int CFG_BITS     = 32;
  localparam int POWER_BITS   = 4;
  localparam int BASE_BITS    = 32;
  localparam int RESULT_BITS  = 64;
  localparam int STEP_BITS    = 3;

  localparam logic signed [CFG_BITS-1:0] OFFSET_RESET = 32'sd65536;
  localparam logic [POWER_BITS-1:0]      POWER_RESET  = 4'd2;
  localparam logic [POWER_BITS-1:0]      POWER_MAX    = 4'd8;

  typedef enum logic [0:0] {
    CFG_OFFSET = 1'b0,
    CFG_POWER  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [FEATURE_BITS-1:0] left_feature;
    logic signed [FEATURE_BITS-1:0] right_feature;
    logic                           final_pair;
  } feature_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] kernel_value;
    logic                          overflowed;
  } kernel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_BASE,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FIX,
    ST_DONE
  } pke_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic mac;
    logic round;
    logic base;
    logic mul_lo;
    logic mul_hi;
    logic fix;
    logic load_out;
  } pke_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_flag;
    logic steps_zero;
    logic out_free;
  } pke_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pke_ctrl.sv =====
// ----------------------------------------------------------------------------
// pke_ctrl
// Sequencer for the multiply-accumulate, base forming and power steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pke_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 feature_valid,
  input  wire pke_pkg::pke_status_t status,
  output pke_pkg::pke_cmd_t         cmd
);

  pke_pkg::pke_state_t state;
  pke_pkg::pke_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pke_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pke_pkg::ST_IDLE: begin
        if (feature_valid) begin
          state_next = pke_pkg::ST_MAC;
        end
      end
      pke_pkg::ST_MAC: begin
        state_next = status.final_flag ? pke_pkg::ST_ROUND : pke_pkg::ST_IDLE;
      end
      pke_pkg::ST_ROUND:  state_next = pke_pkg::ST_BASE;
      pke_pkg::ST_BASE:   state_next = pke_pkg::ST_TEST;
      pke_pkg::ST_TEST: begin
        state_next = status.steps_zero ? pke_pkg::ST_DONE : pke_pkg::ST_MUL_LO;
      end
      pke_pkg::ST_MUL_LO: state_next = pke_pkg::ST_MUL_HI;
      pke_pkg::ST_MUL_HI: state_next = pke_pkg::ST_FIX;
      pke_pkg::ST_FIX:    state_next = pke_pkg::ST_TEST;
      pke_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = pke_pkg::ST_IDLE;
        end
      end
      default:            state_next = pke_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      pke_pkg::ST_IDLE:   cmd.take     = 1'b1;
      pke_pkg::ST_MAC:    cmd.mac      = 1'b1;
      pke_pkg::ST_ROUND:  cmd.round    = 1'b1;
      pke_pkg::ST_BASE:   cmd.base     = 1'b1;
      pke_pkg::ST_TEST:   cmd          = '0;
      pke_pkg::ST_MUL_LO: cmd.mul_lo   = 1'b1;
      pke_pkg::ST_MUL_HI: cmd.mul_hi   = 1'b1;
      pke_pkg::ST_FIX:    cmd.fix      = 1'b1;
      pke_pkg::ST_DONE:   cmd.load_out = status.out_free;
      default:            cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pke_datapath.sv =====
// ----------------------------------------------------------------------------
// pke_datapath
// Feature multiplier, saturating accumulator, base forming, shared power
// multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pke_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  feature_valid,
  input  wire pke_pkg::feature_t                     feature_data,
  input  wire logic                                  cfg_wen,
  input  wire pke_pkg::cfg_index_t                   cfg_index,
  input  wire logic [pke_pkg::CFG_BITS-1:0]          cfg_wdata,
  input  wire logic                                  kernel_stall,
  input  wire pke_pkg::pke_cmd_t                     cmd,
  output pke_pkg::pke_status_t                       status,
  output logic                                       kernel_valid,
  output pke_pkg::kernel_t                           kernel_data
);

  localparam int FB        = pke_pkg::FEATURE_BITS;
  localparam int AB        = pke_pkg::ACC_BITS;
  localparam int PROD_BITS = 2 * FB;
  localparam int SUM_BITS  = ((PROD_BITS > AB) ? PROD_BITS : AB) + 1;
  localparam int RND_BITS  = AB - 8 + 1;
  localparam int BSUM_BITS = RND_BITS + 1;
  localparam int BB        = pke_pkg::BASE_BITS;
  localparam int RB        = pke_pkg::RESULT_BITS;
  localparam int SB        = pke_pkg::STEP_BITS;

  localparam logic [RB-1:0] POS_LIMIT = {1'b0, {(RB-1){1'b1}}};
  localparam logic [RB-1:0] NEG_LIMIT = {1'b1, {(RB-1){1'b0}}};
  localparam logic [RB-1:0] HI_LIMIT  = {{(RB-48){1'b0}}, 1'b1, {47{1'b0}}};

  // Configuration registers.
  logic signed [pke_pkg::CFG_BITS-1:0] offset;
  logic [pke_pkg::POWER_BITS-1:0]      power;

  // Accumulation.
  logic signed [PROD_BITS-1:0] feat_prod;
  logic                        final_flag;
  logic signed [AB-1:0]        acc;
  logic                        sticky;

  // Base and power loop.
  logic signed [RND_BITS-1:0]  rnd;
  logic                        ovf;
  logic [BB-1:0]               bmag;
  logic                        bneg;
  logic                        neg;
  logic [RB-1:0]               rmag;
  logic [RB-1:0]               mprod;
  logic [RB-17:0]              lo_rnd;
  logic [SB-1:0]               steps;

  // Combinational terms.
  logic signed [PROD_BITS-1:0] left_ext;
  logic signed [PROD_BITS-1:0] right_ext;
  logic signed [SUM_BITS-1:0]  mac_sum;
  logic                        mac_ovf;
  logic signed [AB-1:0]        mac_clamped;
  logic [AB:0]                 rnd_sum;
  logic signed [BSUM_BITS-1:0] base_sum;
  logic                        base_ovf;
  logic signed [BB-1:0]        base_clamped;
  logic                        base_neg;
  logic [BB:0]                 base_abs;
  logic [SB-1:0]               steps_init;
  logic [BB-1:0]               mul_a;
  logic [RB-1:0]               mul_p;
  logic [RB-1:0]               lo_sum;
  logic                        neg_step;
  logic [RB-1:0]               limit;
  logic                        hi_big;
  logic [RB:0]                 q;
  logic                        fix_ovf;
  logic [RB-1:0]               rmag_next;

  assign left_ext  = {{FB{feature_data.left_feature[FB-1]}}, feature_data.left_feature};
  assign right_ext = {{FB{feature_data.right_feature[FB-1]}}, feature_data.right_feature};

  // Accumulator add with clamp to the 48-bit signed range.
  assign mac_sum = {{(SUM_BITS-AB){acc[AB-1]}}, acc}
                 + {{(SUM_BITS-PROD_BITS){feat_prod[PROD_BITS-1]}}, feat_prod};
  assign mac_ovf = !((&mac_sum[SUM_BITS-1:AB-1]) || !(|mac_sum[SUM_BITS-1:AB-1]));
  assign mac_clamped = mac_ovf ? (mac_sum[SUM_BITS-1] ? {1'b1, {(AB-1){1'b0}}}
                                                      : {1'b0, {(AB-1){1'b1}}})
                               : mac_sum[AB-1:0];

  // Q23.24 to Q.16, rounding half toward plus infinity.
  assign rnd_sum = {acc[AB-1], acc} + (AB+1)'(128);

  assign base_sum = {rnd[RND_BITS-1], rnd}
                  + {{(BSUM_BITS-pke_pkg::CFG_BITS){offset[pke_pkg::CFG_BITS-1]}}, offset};
  assign base_ovf = !((&base_sum[BSUM_BITS-1:BB-1]) || !(|base_sum[BSUM_BITS-1:BB-1]));
  assign base_clamped = base_ovf ? (base_sum[BSUM_BITS-1] ? {1'b1, {(BB-1){1'b0}}}
                                                          : {1'b0, {(BB-1){1'b1}}})
                                 : base_sum[BB-1:0];
  assign base_neg = base_clamped[BB-1];
  assign base_abs = base_neg ? ((BB+1)'(0) - {base_clamped[BB-1], base_clamped})
                             : {1'b0, base_clamped};

  // Power zero acts as one and powers above the maximum act as the maximum.
  always_comb begin
    if (power == '0) begin
      steps_init = '0;
    end else if (power > pke_pkg::POWER_MAX) begin
      steps_init = SB'(pke_pkg::POWER_MAX - 1'b1);
    end else begin
      steps_init = SB'(power - 1'b1);
    end
  end

  // One 32x32 multiplier, used for the low then the high half of the result.
  assign mul_a = cmd.mul_hi ? rmag[RB-1:BB] : rmag[BB-1:0];
  assign mul_p = {{BB{1'b0}}, mul_a} * {{BB{1'b0}}, bmag};

  assign lo_sum = mprod + RB'(32768);

  assign neg_step = neg ^ bneg;
  assign limit    = neg_step ? NEG_LIMIT : POS_LIMIT;
  assign hi_big   = mprod > HI_LIMIT;
  assign q        = {1'b0, mprod[47:0], 16'b0} + {17'b0, lo_rnd};
  assign fix_ovf  = hi_big || (q > {1'b0, limit});
  assign rmag_next = fix_ovf ? limit : q[RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= pke_pkg::OFFSET_RESET;
      power  <= pke_pkg::POWER_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pke_pkg::CFG_OFFSET: offset <= cfg_wdata;
        pke_pkg::CFG_POWER:  power  <= cfg_wdata[pke_pkg::POWER_BITS-1:0];
        default:             offset <= offset;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      sticky <= 1'b0;
    end else if (cmd.mac) begin
      acc    <= mac_clamped;
      sticky <= sticky | mac_ovf;
    end else if (cmd.round) begin
      acc    <= '0;
      sticky <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_valid <= 1'b0;
    end else if (cmd.load_out) begin
      kernel_valid <= 1'b1;
    end else if (!kernel_stall) begin
      kernel_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take && feature_valid) begin
      feat_prod  <= left_ext * right_ext;
      final_flag <= feature_data.final_pair;
    end
    if (cmd.round) begin
      rnd <= rnd_sum[AB:8];
      ovf <= sticky;
    end
    if (cmd.base) begin
      bmag  <= base_abs[BB-1:0];
      bneg  <= base_neg;
      neg   <= base_neg;
      rmag  <= {16'b0, base_abs[BB-1:0], 16'b0};
      ovf   <= ovf | base_ovf;
      steps <= steps_init;
    end
    if (cmd.mul_lo) begin
      mprod <= mul_p;
    end
    if (cmd.mul_hi) begin
      mprod  <= mul_p;
      lo_rnd <= lo_sum[RB-1:16];
    end
    if (cmd.fix) begin
      rmag  <= rmag_next;
      neg   <= neg_step;
      ovf   <= ovf | fix_ovf;
      steps <= steps - 1'b1;
    end
    if (cmd.load_out) begin
      kernel_data.kernel_value <= neg ? (RB'(0) - rmag) : rmag;
      kernel_data.overflowed   <= ovf;
    end
  end

  assign status.final_flag = final_flag;
  assign status.steps_zero = (steps == '0);
  assign status.out_free   = !kernel_valid || !kernel_stall;

endmodule

`default_nettype wire

// ===== rtl/core/polynomial_kernel_eval.sv =====
// ----------------------------------------------------------------------------
// polynomial_kernel_eval
// Polynomial kernel (dot(x, y) + offset) ^ power in fixed point, one feature
// pair per transfer, one kernel value per vector pair.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  feature   | feature_valid / feature_stall | pke_pkg::feature_t
//  kernel    | kernel_valid / kernel_stall   | pke_pkg::kernel_t
//  config    | cfg_wen, cfg_index            | cfg_wdata
//
// A feature pair's product is registered in the idle state and accumulated
// in the MAC state. A final pair runs power steps, power clamped to 1..8;
// each power step runs the shared 32x32 multiplier twice and then rounds.
// A new pair is taken while a finished kernel value waits in the output
// register; a second result waits for that register to drain.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module polynomial_kernel_eval (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         feature_valid,
  output logic                              feature_stall,
  input  wire pke_pkg::feature_t            feature_data,
  output logic                              kernel_valid,
  input  wire logic                         kernel_stall,
  output pke_pkg::kernel_t                  kernel_data,
  input  wire logic                         cfg_wen,
  input  wire pke_pkg::cfg_index_t          cfg_index,
  input  wire logic [pke_pkg::CFG_BITS-1:0] cfg_wdata
);

  pke_pkg::pke_cmd_t    cmd;
  pke_pkg::pke_status_t status;

  pke_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .feature_valid (feature_valid),
    .status        (status),
    .cmd           (cmd)
  );

  pke_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .feature_valid (feature_valid),
    .feature_data  (feature_data),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .kernel_stall  (kernel_stall),
    .cmd           (cmd),
    .status        (status),
    .kernel_valid  (kernel_valid),
    .kernel_data   (kernel_data)
  );

  assign feature_stall = !cmd.take;

  // The controller never overwrites a result that has not been transferred.
  `PKE_ASSERT(a_load_only_when_free, clk, rst, cmd.load_out |-> status.out_free)
  // A new result appears only after the controller loaded it.
  `PKE_ASSERT(a_valid_from_load, clk, rst, $rose(kernel_valid) |-> $past(cmd.load_out))
  // At most one datapath operation is commanded in any cycle.
  `PKE_ASSERT_ALWAYS(a_one_command, clk, $onehot0(cmd))

endmodule

`default_nettype wire

// ===== tb/sv/tb_polynomial_kernel_eval.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_kernel_eval
// Self-checking bench for the polynomial kernel block. A directed table covers
// the reset setting, the field and register extremes, the power clamping and
// the base saturation flag. A randomized part follows with random vector
// lengths, feature magnitudes and register settings, bursty input traffic and
// a patterned output stall. Every kernel value is checked against an in-bench
// fixed-point predictor, or against the fixed value of a pinned table row.
// ----------------------------------------------------------------------------

module tb_polynomial_kernel_eval;

  localparam int RANDOM_ITEMS   = 1730;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int SQUEEZE_VECS   = 24;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam longint ACC_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOTTOM  = -ACC_TOP - 1;
  localparam longint BASE_TOP    = 64'sd2147483647;
  localparam longint BASE_BOTTOM = -64'sd2147483648;
  localparam bit [63:0] POS_CLAMP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] NEG_CLAMP = 64'h8000_0000_0000_0000;

  typedef struct {
    bit                 is_setting;
    logic [31:0]        set_offset;
    logic [31:0]        set_power;
    pke_pkg::feature_t  pair;
    bit                 pinned;
    pke_pkg::kernel_t   want;
  } probe_row_t;

  logic                         clk;
  logic                         rst;
  logic                         feature_valid;
  logic                         feature_stall;
  pke_pkg::feature_t            feature_data;
  logic                         kernel_valid;
  logic                         kernel_stall;
  pke_pkg::kernel_t             kernel_data;
  logic                         cfg_wen;
  pke_pkg::cfg_index_t          cfg_index;
  logic [pke_pkg::CFG_BITS-1:0] cfg_wdata;

  // Predictor state: register copies and the running dot product.
  logic signed [31:0] offset_q;
  logic [3:0]         power_q;
  longint             dot_acc;
  bit                 dot_sticky;

  pke_pkg::kernel_t pending_kernels[$];
  pke_pkg::kernel_t head_kernel;
  probe_row_t       probes[$];
  int               mismatch_count;
  int               quiet_cycles;
  int               burst_left;
  bit               pacing;
  int               squeeze_requests;
  int               squeeze_served;

  polynomial_kernel_eval u_dut (
    .clk           (clk),
    .rst           (rst),
    .feature_valid (feature_valid),
    .feature_stall (feature_stall),
    .feature_data  (feature_data),
    .kernel_valid  (kernel_valid),
    .kernel_stall  (kernel_stall),
    .kernel_data   (kernel_data),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Adds one feature product into the dot product; on a final pair it also
  // forms the kernel value and returns 1.
  function automatic bit accumulate_pair(input pke_pkg::feature_t f,
                                         output pke_pkg::kernel_t k);
    longint    sum;
    longint    base_v;
    bit        base_neg;
    bit        neg;
    bit        ovf;
    bit [63:0] bmag;
    bit [63:0] rmag;
    bit [63:0] limit;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] q;
    int        p;
    k = '0;
    sum = dot_acc + longint'($signed(f.left_feature)) * longint'($signed(f.right_feature));
    if (sum > ACC_TOP) begin
      sum = ACC_TOP;
      dot_sticky = 1'b1;
    end else if (sum < ACC_BOTTOM) begin
      sum = ACC_BOTTOM;
      dot_sticky = 1'b1;
    end
    dot_acc = sum;
    if (!f.final_pair) return 1'b0;

    ovf = dot_sticky;
    // Q23.24 to Q.16 with round half up; the bias keeps the shift on a
    // non-negative value.
    base_v = ((dot_acc - ACC_BOTTOM + 128) >> 8) - (longint'(1) << 39);
    base_v = base_v + longint'(offset_q);
    if (base_v > BASE_TOP) begin
      base_v = BASE_TOP;
      ovf = 1'b1;
    end else if (base_v < BASE_BOTTOM) begin
      base_v = BASE_BOTTOM;
      ovf = 1'b1;
    end

    p = power_q;
    if (p < 1) p = 1;
    if (p > 8) p = 8;

    base_neg = (base_v < 0);
    neg = base_neg;
    bmag = base_neg ? -base_v : base_v;
    rmag = bmag << 16;
    for (int s = 1; s < p; s++) begin
      neg = neg ^ base_neg;
      limit = neg ? NEG_CLAMP : POS_CLAMP;
      lo = (rmag & 64'hFFFF_FFFF) * bmag;
      hi = (rmag >> 32) * bmag;
      if (hi > (64'd1 << 47)) begin
        ovf = 1'b1;
        rmag = limit;
      end else begin
        q = (hi << 16) + ((lo + 64'd32768) >> 16);
        if (q > limit) begin
          ovf = 1'b1;
          rmag = limit;
        end else begin
          rmag = q;
        end
      end
    end

    k.kernel_value = neg ? (64'd0 - rmag) : rmag;
    k.overflowed = ovf;
    dot_acc = 0;
    dot_sticky = 1'b0;
    return 1'b1;
  endfunction

  function automatic probe_row_t pair_row(input logic [15:0] l, input logic [15:0] r,
                                          input bit fin);
    probe_row_t row;
    row = '{default: '0};
    row.pair.left_feature = l;
    row.pair.right_feature = r;
    row.pair.final_pair = fin;
    return row;
  endfunction

  function automatic probe_row_t pinned_row(input logic [15:0] l, input logic [15:0] r,
                                            input logic [63:0] kv, input bit ov);
    probe_row_t row;
    row = pair_row(l, r, 1'b1);
    row.pinned = 1'b1;
    row.want.kernel_value = kv;
    row.want.overflowed = ov;
    return row;
  endfunction

  function automatic probe_row_t setting_row(input logic [31:0] off, input logic [3:0] pw);
    probe_row_t row;
    row = '{default: '0};
    row.is_setting = 1'b1;
    row.set_offset = off;
    row.set_power = {28'd0, pw};
    return row;
  endfunction

  function automatic logic [15:0] pick_feature(input int fclass);
    case (fclass)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191) - 4096);
      2: return 16'($urandom_range(0, 511) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offers one pair until it transfers, records its expectation, then maybe
  // drops valid for a gap between bursts.
  task automatic send_pair(input pke_pkg::feature_t f, input bit pinned,
                           input pke_pkg::kernel_t want);
    pke_pkg::kernel_t predicted;
    int               gap;
    feature_valid <= 1'b1;
    feature_data <= f;
    @(posedge clk);
    while (feature_stall) @(posedge clk);
    if (accumulate_pair(f, predicted)) pending_kernels.push_back(pinned ? want : predicted);
    if (pacing) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(0, 15);
        gap = $urandom_range(1, 14);
        feature_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Registers change only once the block has drained and gone quiet.
  task automatic apply_setting(input logic [31:0] off, input logic [31:0] pw_word);
    feature_valid <= 1'b0;
    while (pending_kernels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= pke_pkg::CFG_OFFSET;
    cfg_wdata <= off;
    @(posedge clk);
    offset_q = off;
    cfg_index <= pke_pkg::CFG_POWER;
    cfg_wdata <= pw_word;
    @(posedge clk);
    power_q = pw_word[3:0];
    cfg_wen <= 1'b0;
  endtask

  initial begin : stimulus
    pke_pkg::feature_t f;
    logic [31:0]       off_pick;
    logic [31:0]       pw_word;
    int                done_items;
    int                vec_len;
    int                vec_count;
    int                fclass;
    rst <= 1'b1;
    feature_valid <= 1'b0;
    feature_data <= '0;
    cfg_wen <= 1'b0;
    cfg_index <= pke_pkg::CFG_OFFSET;
    cfg_wdata <= '0;
    offset_q = pke_pkg::OFFSET_RESET;
    power_q = pke_pkg::POWER_RESET;
    dot_acc = 0;
    dot_sticky = 1'b0;
    pacing = 1'b1;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    probes = '{
      pinned_row(16'h0000, 16'h0000, 64'h0000_0001_0000_0000, 1'b0),
      pinned_row(16'h8000, 16'h8000, 64'h0000_1081_0000_0000, 1'b0),
      pair_row(16'h7FFF, 16'h8000, 1'b0),
      pair_row(16'h7FFF, 16'h7FFF, 1'b0),
      pair_row(16'hFFFF, 16'h0001, 1'b1),
      pair_row(16'h0001, 16'h0080, 1'b1),
      pair_row(16'hFFFF, 16'h0080, 1'b1),
      setting_row(32'h0001_0000, 4'd0),
      pinned_row(16'h1000, 16'h1000, 64'h0000_0002_0000_0000, 1'b0),
      setting_row(32'h7FFF_FFFF, 4'd8),
      pinned_row(16'h7FFF, 16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1),
      setting_row(32'h7FFF_FFFF, 4'd15),
      pinned_row(16'h8000, 16'h8000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1),
      setting_row(32'h8000_0000, 4'd3),
      pinned_row(16'h0000, 16'h0000, 64'h8000_0000_0000_0000, 1'b1),
      pinned_row(16'h8000, 16'h7FFF, 64'h8000_0000_0000_0000, 1'b1),
      setting_row(32'h0000_0000, 4'd1),
      pinned_row(16'h0000, 16'h0000, 64'h0000_0000_0000_0000, 1'b0),
      pair_row(16'h0001, 16'h0001, 1'b0),
      pair_row(16'hFFFF, 16'hFFFF, 1'b0),
      pair_row(16'h3039, 16'hFCF7, 1'b1),
      setting_row(32'hFFFF_0000, 4'd4),
      pinned_row(16'h0000, 16'h0000, 64'h0000_0001_0000_0000, 1'b0),
      pair_row(16'h1000, 16'h1000, 1'b1),
      setting_row(32'hFFFF_0000, 4'd5),
      pinned_row(16'h0000, 16'h0000, 64'hFFFF_FFFF_0000_0000, 1'b0),
      pair_row(16'hAAAA, 16'h5555, 1'b1)
    };
    foreach (probes[i]) begin
      if (probes[i].is_setting) begin
        apply_setting(probes[i].set_offset, probes[i].set_power);
      end else begin
        send_pair(probes[i].pair, probes[i].pinned, probes[i].want);
      end
    end

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: off_pick = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        6, 7: off_pick = $urandom;
        default: begin
          case ($urandom_range(0, 4))
            0: off_pick = 32'h7FFF_FFFF;
            1: off_pick = 32'h8000_0000;
            2: off_pick = 32'h0000_0000;
            3: off_pick = 32'h0001_0000;
            default: off_pick = 32'hFFFF_0000;
          endcase
        end
      endcase
      pw_word = ($urandom & 32'hFFFF_FFF0) |
                (($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
      apply_setting(off_pick, pw_word);

      // A long hold on the output starts during a long run of vectors, so
      // the sender keeps offering pairs while the block backs up.
      vec_count = $urandom_range(3, 16);
      if (squeeze_requests == 0 ||
          (done_items > RANDOM_ITEMS / 2 && squeeze_requests < 2)) begin
        squeeze_requests++;
        vec_count = SQUEEZE_VECS;
      end

      repeat (vec_count) begin
        case ($urandom_range(0, 19)) inside
          [0:11]:  vec_len = $urandom_range(1, 6);
          [12:17]: vec_len = $urandom_range(7, 24);
          default: vec_len = $urandom_range(25, 80);
        endcase
        if (vec_len > RANDOM_ITEMS - done_items) vec_len = RANDOM_ITEMS - done_items;
        fclass = $urandom_range(0, 3);
        for (int n = 0; n < vec_len; n++) begin
          f.left_feature = pick_feature(fclass);
          f.right_feature = pick_feature(fclass);
          f.final_pair = (n == vec_len - 1);
          send_pair(f, 1'b0, '0);
          done_items++;
        end
      end
    end

    feature_valid <= 1'b0;
    while (pending_kernels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Output side: stall in chunks of varying density, with an occasional long
  // hold so that the block backs up into its input.
  initial begin : receiver
    int mode;
    int len;
    int thresh;
    kernel_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_served < squeeze_requests) begin
        squeeze_served++;
        kernel_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 60);
      case (mode)
        0: thresh = 0;
        1: thresh = 30;
        2: thresh = 80;
        default: thresh = 50;
      endcase
      repeat (len) begin
        kernel_stall <= ($urandom_range(0, 99) < thresh);
        @(posedge clk);
      end
    end
  end

  // Each kernel transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && kernel_valid && !kernel_stall) begin
      if (pending_kernels.size() == 0) begin
        report_mismatch("unexpected kernel transfer", kernel_data.kernel_value, '0);
      end else begin
        head_kernel = pending_kernels.pop_front();
        if (kernel_data.kernel_value !== head_kernel.kernel_value)
          report_mismatch("kernel_value", kernel_data.kernel_value, head_kernel.kernel_value);
        if (kernel_data.overflowed !== head_kernel.overflowed)
          report_mismatch("overflowed", 64'(kernel_data.overflowed),
                          64'(head_kernel.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (feature_valid && !feature_stall) || (kernel_valid && !kernel_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pke_pkg.sv
rtl/core/pke_ctrl.sv
rtl/core/pke_datapath.sv
rtl/core/polynomial_kernel_eval.sv
tb/sv/tb_polynomial_kernel_eval.sv
